/* sv/prpd_pkg.sv */
// ----------------------------------------------------------------------------
// prpd_pkg
// Shared constants for the pinhole primary ray direction generator.
// ----------------------------------------------------------------------------
package prpd_pkg;

    localparam int PIXEL_COORD_BITS_DEF = 12;

    localparam int SIZE_W  = 13;   // image width and height registers
    localparam int SCALE_W = 31;   // unsigned Q7.24 scales
    localparam int DIR_W   = 32;   // signed Q8.24 view direction, Q2.30 result
    localparam int CFG_W   = 32;

    // The largest normalized magnitude keeps its leading one at this bit.
    localparam int NORM_MSB = 30;
    localparam int NORM_W   = NORM_MSB + 1;
    localparam int SUMSQ_W  = 64;
    localparam int ROOT_W   = SUMSQ_W / 2;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH      = 3'd0,
        CFG_IMAGE_HEIGHT     = 3'd1,
        CFG_HORIZONTAL_SCALE = 3'd2,
        CFG_VERTICAL_SCALE   = 3'd3,
        CFG_VIEW_DIR_X       = 3'd4,
        CFG_VIEW_DIR_Y       = 3'd5,
        CFG_VIEW_DIR_Z       = 3'd6
    } cfg_index_t;

    localparam logic [SIZE_W-1:0]  IMAGE_WIDTH_RST      = 13'd640;
    localparam logic [SIZE_W-1:0]  IMAGE_HEIGHT_RST     = 13'd480;
    localparam logic [SCALE_W-1:0] HORIZONTAL_SCALE_RST = 31'd12915101;
    localparam logic [SCALE_W-1:0] VERTICAL_SCALE_RST   = 31'd9686326;
    localparam logic [DIR_W-1:0]   VIEW_DIR_X_RST       = 32'h0000_0000;
    localparam logic [DIR_W-1:0]   VIEW_DIR_Y_RST       = 32'h0000_0000;
    localparam logic [DIR_W-1:0]   VIEW_DIR_Z_RST       = 32'hFF00_0000;

endpackage

/* sv/pinhole_primary_ray_direction.sv */
// ----------------------------------------------------------------------------
// pinhole_primary_ray_direction
// Maps a pixel to the unit direction of the primary ray through its center.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Role
//  s_        s_valid/s_ready, s_pixel_x, s_pixel_y   pixel in
//  m_        m_valid/m_ready, m_ray_dir_*, zero_len  ray direction out
//  cfg_      cfg_valid/cfg_ready, cfg_index, data    register writes
//
// One pixel is taken every cycle while the output is not stalled. A pixel passes
// through stages A and B, the pixel offset dividers, stages C to I, the 32-stage
// square root, the final scaling dividers and the output register. Reset is
// synchronous; it clears the valid bits and loads the camera registers with
// their defaults, while data registers are not reset.
// A stall on m_ready freezes the whole pipeline and also drops s_ready.
// ----------------------------------------------------------------------------
module pinhole_primary_ray_direction #(
    parameter int PIXEL_COORD_BITS = prpd_pkg::PIXEL_COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [PIXEL_COORD_BITS-1:0]       s_pixel_x,
    input  logic [PIXEL_COORD_BITS-1:0]       s_pixel_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [prpd_pkg::DIR_W-1:0] m_ray_dir_x,
    output logic signed [prpd_pkg::DIR_W-1:0] m_ray_dir_y,
    output logic signed [prpd_pkg::DIR_W-1:0] m_ray_dir_z,
    output logic                              m_zero_length,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [prpd_pkg::CFG_W-1:0]        cfg_data
);

    localparam int SW   = prpd_pkg::SIZE_W;
    localparam int DW   = prpd_pkg::DIR_W;
    localparam int NXW  = ((PIXEL_COORD_BITS + 1 > SW) ? PIXEL_COORD_BITS + 1 : SW) + 1;
    localparam int PRW  = NXW - 1 + prpd_pkg::SCALE_W;
    localparam int NUMW = PRW + 1;
    localparam int CW   = NUMW + 2;
    localparam int LPW  = $clog2(CW);
    localparam int NMW  = prpd_pkg::NORM_W;
    localparam int SQW  = 2 * NMW;
    localparam int SMW  = prpd_pkg::SUMSQ_W;
    localparam int RTW  = prpd_pkg::ROOT_W;
    localparam int REMW = RTW + 2;
    localparam int FNW  = 2 * NMW;
    localparam int TAGW = 3 * NMW + 4;

    // Configuration registers.
    logic [SW-1:0]                      image_width_reg, image_height_reg;
    logic [prpd_pkg::SCALE_W-1:0]       hscale_reg, vscale_reg;
    logic signed [DW-1:0]               view_x_reg, view_y_reg, view_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= prpd_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= prpd_pkg::IMAGE_HEIGHT_RST;
            hscale_reg       <= prpd_pkg::HORIZONTAL_SCALE_RST;
            vscale_reg       <= prpd_pkg::VERTICAL_SCALE_RST;
            view_x_reg       <= prpd_pkg::VIEW_DIR_X_RST;
            view_y_reg       <= prpd_pkg::VIEW_DIR_Y_RST;
            view_z_reg       <= prpd_pkg::VIEW_DIR_Z_RST;
        end else if (cfg_valid) begin
            case (prpd_pkg::cfg_index_t'(cfg_index))
                prpd_pkg::CFG_IMAGE_WIDTH:      image_width_reg  <= cfg_data[SW-1:0];
                prpd_pkg::CFG_IMAGE_HEIGHT:     image_height_reg <= cfg_data[SW-1:0];
                prpd_pkg::CFG_HORIZONTAL_SCALE: hscale_reg <= cfg_data[prpd_pkg::SCALE_W-1:0];
                prpd_pkg::CFG_VERTICAL_SCALE:   vscale_reg <= cfg_data[prpd_pkg::SCALE_W-1:0];
                prpd_pkg::CFG_VIEW_DIR_X:       view_x_reg <= cfg_data;
                prpd_pkg::CFG_VIEW_DIR_Y:       view_y_reg <= cfg_data;
                prpd_pkg::CFG_VIEW_DIR_Z:       view_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A zero image size is treated as one.
    logic [SW-1:0] w_eff, h_eff;
    assign w_eff = (image_width_reg == '0) ? SW'(1) : image_width_reg;
    assign h_eff = (image_height_reg == '0) ? SW'(1) : image_height_reg;

    logic en;
    logic m_valid_reg;
    assign en      = m_ready | ~m_valid_reg;
    assign s_ready = en;

    // Stage A: signed pixel center offsets in half pixels.
    logic                  a_valid_reg;
    logic signed [NXW-1:0] nx_reg, ny_reg;

    // Stage B: magnitude products with the scales.
    logic           b_valid_reg;
    logic           sx_reg, sy_reg;
    logic [PRW-1:0] prodx_reg, prody_reg;
    logic [NXW-2:0] magx, magy;

    assign magx = nx_reg[NXW-1] ? (NXW-1)'(-nx_reg) : nx_reg[NXW-2:0];
    assign magy = ny_reg[NXW-1] ? (NXW-1)'(-ny_reg) : ny_reg[NXW-2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            nx_reg    <= NXW'({s_pixel_x, 1'b1}) - NXW'(w_eff);
            ny_reg    <= NXW'(h_eff) - NXW'({s_pixel_y, 1'b1});
            sx_reg    <= nx_reg[NXW-1];
            sy_reg    <= ny_reg[NXW-1];
            prodx_reg <= PRW'(magx) * PRW'(hscale_reg);
            prody_reg <= PRW'(magy) * PRW'(vscale_reg);
        end
    end

    // Rounded division by the image size, ties away from zero.
    logic            dx_valid, dy_valid, dx_sign, dy_sign;
    logic [NUMW-1:0] qx, qy;

    prpd_div #(.NW(NUMW), .DW(SW), .QW(NUMW), .TW(1)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(b_valid_reg),
        .num(NUMW'(prodx_reg) + NUMW'(w_eff >> 1)), .den(w_eff), .tag_in(sx_reg),
        .out_valid(dx_valid), .quo(qx), .tag_out(dx_sign)
    );

    prpd_div #(.NW(NUMW), .DW(SW), .QW(NUMW), .TW(1)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(b_valid_reg),
        .num(NUMW'(prody_reg) + NUMW'(h_eff >> 1)), .den(h_eff), .tag_in(sy_reg),
        .out_valid(dy_valid), .quo(qy), .tag_out(dy_sign)
    );

    // Stages C..G: signed offsets, sum, magnitudes, leading one, normalize.
    logic                   c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg, g_valid_reg;
    logic signed [NUMW:0]   px_reg, py_reg;
    logic signed [CW-1:0]   sum_c_reg [3];
    logic [CW-1:0]          mag_reg   [3];
    logic [CW-1:0]          magf_reg  [3];
    logic [2:0]             neg_e_reg, neg_f_reg, neg_g_reg;
    logic [LPW-1:0]         pos_reg;
    logic                   zero_f_reg, zero_g_reg;
    logic [NMW-1:0]         norm_reg  [3];
    logic [CW-1:0]          mag_or;
    logic [LPW-1:0]         pos_next;

    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];

    // Position of the leading one of the OR equals that of the largest magnitude.
    always_comb begin
        pos_next = '0;
        for (int i = 0; i < CW; i++) begin
            if (mag_or[i]) begin
                pos_next = LPW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= dx_valid & dy_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
        if (en) begin
            px_reg <= dx_sign ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            py_reg <= dy_sign ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            sum_c_reg[0] <= CW'(view_x_reg) + CW'(px_reg);
            sum_c_reg[1] <= CW'(view_y_reg) + CW'(py_reg);
            sum_c_reg[2] <= CW'(view_z_reg);
            for (int i = 0; i < 3; i++) begin
                neg_e_reg[i] <= sum_c_reg[i][CW-1];
                mag_reg[i]   <= sum_c_reg[i][CW-1] ? CW'(-sum_c_reg[i]) : CW'(sum_c_reg[i]);
            end
            magf_reg   <= mag_reg;
            neg_f_reg  <= neg_e_reg;
            pos_reg    <= pos_next;
            zero_f_reg <= (mag_or == '0);
            for (int i = 0; i < 3; i++) begin
                if (pos_reg >= LPW'(prpd_pkg::NORM_MSB)) begin
                    norm_reg[i] <= NMW'(magf_reg[i] >> (pos_reg - LPW'(prpd_pkg::NORM_MSB)));
                end else begin
                    norm_reg[i] <= NMW'(magf_reg[i] << (LPW'(prpd_pkg::NORM_MSB) - pos_reg));
                end
            end
            neg_g_reg  <= neg_f_reg;
            zero_g_reg <= zero_f_reg;
        end
    end

    // Stages H and I: squares, then their sum.
    logic           h_valid_reg, i_valid_reg;
    logic [SQW-1:0] sq_reg [3];
    logic [SMW-1:0] sumsq_reg;
    logic [TAGW-1:0] h_tag_reg, i_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end else if (en) begin
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQW'(norm_reg[i]) * SQW'(norm_reg[i]);
            end
            h_tag_reg <= {zero_g_reg, neg_g_reg, norm_reg[2], norm_reg[1], norm_reg[0]};
            sumsq_reg <= SMW'(sq_reg[0]) + SMW'(sq_reg[1]) + SMW'(sq_reg[2]);
            i_tag_reg <= h_tag_reg;
        end
    end

    // Integer square root, one root bit per stage.
    logic            rt_valid_reg [RTW];
    logic [RTW-1:0]  root_reg     [RTW];
    logic [REMW-1:0] rrem_reg     [RTW];
    logic [SMW-1:0]  rad_reg      [RTW];
    logic [TAGW-1:0] rt_tag_reg   [RTW];

    genvar k;
    for (k = 0; k < RTW; k++) begin : g_sqrt
        logic            v_i;
        logic [RTW-1:0]  root_i;
        logic [REMW-1:0] rem_i;
        logic [SMW-1:0]  rad_i;
        logic [TAGW-1:0] tag_i;
        logic [REMW+1:0] part;
        logic [REMW+1:0] trial;
        logic            take;

        if (k == 0) begin : g_first
            assign v_i    = i_valid_reg;
            assign root_i = '0;
            assign rem_i  = '0;
            assign rad_i  = sumsq_reg;
            assign tag_i  = i_tag_reg;
        end else begin : g_next
            assign v_i    = rt_valid_reg[k-1];
            assign root_i = root_reg[k-1];
            assign rem_i  = rrem_reg[k-1];
            assign rad_i  = rad_reg[k-1];
            assign tag_i  = rt_tag_reg[k-1];
        end

        assign part  = {rem_i, rad_i[SMW-1:SMW-2]};
        assign trial = (REMW+2)'({root_i, 2'b01});
        assign take  = (part >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_valid_reg[k] <= 1'b0;
            end else if (en) begin
                rt_valid_reg[k] <= v_i;
            end
            if (en) begin
                rrem_reg[k]   <= take ? REMW'(part - trial) : REMW'(part);
                root_reg[k]   <= {root_i[RTW-2:0], take};
                rad_reg[k]    <= rad_i << 2;
                rt_tag_reg[k] <= tag_i;
            end
        end
    end

    logic [RTW-1:0]  len;
    logic [TAGW-1:0] rt_tag;
    logic [NMW-1:0]  nrm [3];

    assign len    = root_reg[RTW-1];
    assign rt_tag = rt_tag_reg[RTW-1];
    assign nrm[0] = rt_tag[NMW-1:0];
    assign nrm[1] = rt_tag[2*NMW-1:NMW];
    assign nrm[2] = rt_tag[3*NMW-1:2*NMW];

    // Final scaling: component * 2^30 / length, rounded to nearest.
    logic           fd_valid [3];
    logic [NMW-1:0] fq       [3];
    logic [1:0]     fd0_tag;
    logic           fd1_neg, fd2_neg;

    prpd_div #(.NW(FNW), .DW(RTW), .QW(NMW), .TW(2)) u_div_out_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rt_valid_reg[RTW-1]),
        .num(FNW'({nrm[0], prpd_pkg::NORM_MSB'(0)}) + FNW'(len >> 1)), .den(len),
        .tag_in({rt_tag[TAGW-1], rt_tag[3*NMW]}),
        .out_valid(fd_valid[0]), .quo(fq[0]), .tag_out(fd0_tag)
    );

    prpd_div #(.NW(FNW), .DW(RTW), .QW(NMW), .TW(1)) u_div_out_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rt_valid_reg[RTW-1]),
        .num(FNW'({nrm[1], prpd_pkg::NORM_MSB'(0)}) + FNW'(len >> 1)), .den(len),
        .tag_in(rt_tag[3*NMW+1]),
        .out_valid(fd_valid[1]), .quo(fq[1]), .tag_out(fd1_neg)
    );

    prpd_div #(.NW(FNW), .DW(RTW), .QW(NMW), .TW(1)) u_div_out_z (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rt_valid_reg[RTW-1]),
        .num(FNW'({nrm[2], prpd_pkg::NORM_MSB'(0)}) + FNW'(len >> 1)), .den(len),
        .tag_in(rt_tag[3*NMW+2]),
        .out_valid(fd_valid[2]), .quo(fq[2]), .tag_out(fd2_neg)
    );

    // Output register.
    logic signed [DW-1:0] rx_reg, ry_reg, rz_reg;
    logic                 zero_out_reg;
    logic                 fzero;

    assign fzero = fd0_tag[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= fd_valid[0] & fd_valid[1] & fd_valid[2];
        end
        if (en) begin
            zero_out_reg <= fzero;
            if (fzero) begin
                rx_reg <= '0;
                ry_reg <= '0;
                rz_reg <= '0;
            end else begin
                rx_reg <= fd0_tag[0] ? -DW'(fq[0]) : DW'(fq[0]);
                ry_reg <= fd1_neg ? -DW'(fq[1]) : DW'(fq[1]);
                rz_reg <= fd2_neg ? -DW'(fq[2]) : DW'(fq[2]);
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ray_dir_x   = rx_reg;
    assign m_ray_dir_y   = ry_reg;
    assign m_ray_dir_z   = rz_reg;
    assign m_zero_length = zero_out_reg;

endmodule

/* sv/prpd_div.sv */
// ----------------------------------------------------------------------------
// prpd_div
// Pipelined restoring divider, one quotient bit per register stage.
// The upper NW-QW numerator bits must be smaller than the divisor.
// ----------------------------------------------------------------------------
module prpd_div #(
    parameter int NW = 45,
    parameter int DW = 13,
    parameter int QW = 45,
    parameter int TW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [TW-1:0] tag_out
);

    logic          valid_reg [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] lo_reg    [QW];
    logic [QW-1:0] quo_reg   [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [TW-1:0] tag_reg   [QW];

    genvar k;
    for (k = 0; k < QW; k++) begin : g_stage
        logic          v_i;
        logic [DW-1:0] rem_i;
        logic [QW-1:0] lo_i;
        logic [QW-1:0] quo_i;
        logic [DW-1:0] den_i;
        logic [TW-1:0] tag_i;
        logic [DW:0]   trial;
        logic          fits;

        if (k == 0) begin : g_first
            assign v_i   = in_valid;
            assign rem_i = DW'(num >> QW);
            assign lo_i  = num[QW-1:0];
            assign quo_i = '0;
            assign den_i = den;
            assign tag_i = tag_in;
        end else begin : g_next
            assign v_i   = valid_reg[k-1];
            assign rem_i = rem_reg[k-1];
            assign lo_i  = lo_reg[k-1];
            assign quo_i = quo_reg[k-1];
            assign den_i = den_reg[k-1];
            assign tag_i = tag_reg[k-1];
        end

        assign trial = {rem_i, lo_i[QW-1]};
        assign fits  = (trial >= {1'b0, den_i});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_i;
            end
            if (en) begin
                rem_reg[k] <= fits ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
                lo_reg[k]  <= lo_i << 1;
                quo_reg[k] <= {quo_i[QW-2:0], fits};
                den_reg[k] <= den_i;
                tag_reg[k] <= tag_i;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign tag_out   = tag_reg[QW-1];

endmodule

/* sv/prpd_chk.sv */
// ----------------------------------------------------------------------------
// prpd_chk
// Port-level checks for the ray direction generator, bound to the top level.
// ----------------------------------------------------------------------------
module prpd_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [prpd_pkg::DIR_W-1:0] m_ray_dir_x,
    input logic signed [prpd_pkg::DIR_W-1:0] m_ray_dir_y,
    input logic signed [prpd_pkg::DIR_W-1:0] m_ray_dir_z,
    input logic                              m_zero_length
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_ray_dir_x) && $stable(m_ray_dir_y)
                                && $stable(m_ray_dir_z) && $stable(m_zero_length))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with an empty output register");

    a_zero_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_length |->
            m_ray_dir_x == 0 && m_ray_dir_y == 0 && m_ray_dir_z == 0)
        else $error("zero-length flag with a nonzero direction");

    a_unit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_zero_length |->
            m_ray_dir_x != 0 || m_ray_dir_y != 0 || m_ray_dir_z != 0)
        else $error("normalized direction is all zero");

endmodule

bind pinhole_primary_ray_direction prpd_chk u_prpd_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ray_dir_x   (m_ray_dir_x),
    .m_ray_dir_y   (m_ray_dir_y),
    .m_ray_dir_z   (m_ray_dir_z),
    .m_zero_length (m_zero_length)
);

/* dv/tb_pinhole_primary_ray_direction.sv */
// ----------------------------------------------------------------------------
// tb_pinhole_primary_ray_direction
// Streams pixels through the ray direction generator under several camera
// setups and handshake pressure patterns. A bit-accurate predictor computes
// each expected unit vector, and the monitor checks every output transaction.
// ----------------------------------------------------------------------------
module tb_pinhole_primary_ray_direction;

    localparam int COORD_W   = prpd_pkg::PIXEL_COORD_BITS_DEF;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pixel_t;

    typedef struct {
        logic signed [prpd_pkg::DIR_W-1:0] dx;
        logic signed [prpd_pkg::DIR_W-1:0] dy;
        logic signed [prpd_pkg::DIR_W-1:0] dz;
        logic                              zero;
    } ray_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [COORD_W-1:0]                s_pixel_x;
    logic [COORD_W-1:0]                s_pixel_y;
    logic                              m_valid;
    logic                              m_ready;
    logic signed [prpd_pkg::DIR_W-1:0] m_ray_dir_x;
    logic signed [prpd_pkg::DIR_W-1:0] m_ray_dir_y;
    logic signed [prpd_pkg::DIR_W-1:0] m_ray_dir_z;
    logic                              m_zero_length;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [2:0]                        cfg_index;
    logic [prpd_pkg::CFG_W-1:0]        cfg_data;

    // Camera registers as the block should hold them.
    logic [prpd_pkg::SIZE_W-1:0]       cam_width;
    logic [prpd_pkg::SIZE_W-1:0]       cam_height;
    logic [prpd_pkg::SCALE_W-1:0]      cam_hscale;
    logic [prpd_pkg::SCALE_W-1:0]      cam_vscale;
    logic signed [prpd_pkg::DIR_W-1:0] cam_dir_x;
    logic signed [prpd_pkg::DIR_W-1:0] cam_dir_y;
    logic signed [prpd_pkg::DIR_W-1:0] cam_dir_z;

    pixel_t pending_pixels[$];
    ray_t   expected_rays[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     error_count;
    int     cycle_count;
    int     rays_checked;
    int     zero_rays_seen;
    bit     pixel_taken;

    pinhole_primary_ray_direction u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel_x(s_pixel_x), .s_pixel_y(s_pixel_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_ray_dir_x(m_ray_dir_x), .m_ray_dir_y(m_ray_dir_y),
        .m_ray_dir_z(m_ray_dir_z), .m_zero_length(m_zero_length),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint div_round_away(longint num, longint den);
        longint q;
        q = ((num < 0 ? -num : num) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic bit [63:0] floor_sqrt(bit [63:0] s);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic ray_t predict_ray(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        longint    w;
        longint    h;
        longint    off_x;
        longint    off_y;
        longint    c[3];
        bit [63:0] m[3];
        bit [63:0] big;
        bit [63:0] len;
        bit [63:0] q;
        bit [63:0] r[3];
        ray_t      ray;
        w = (cam_width == 0) ? 1 : longint'(cam_width);
        h = (cam_height == 0) ? 1 : longint'(cam_height);
        off_x = div_round_away((2 * longint'(x) + 1 - w) * longint'(cam_hscale), w);
        off_y = div_round_away((h - 2 * longint'(y) - 1) * longint'(cam_vscale), h);
        c[0] = longint'(cam_dir_x) + off_x;
        c[1] = longint'(cam_dir_y) + off_y;
        c[2] = longint'(cam_dir_z);
        big = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] > big) big = m[i];
        end
        if (big == 0) begin
            ray.dx = '0;
            ray.dy = '0;
            ray.dz = '0;
            ray.zero = 1'b1;
            return ray;
        end
        // Bring the largest magnitude into [2^30, 2^31) before the root.
        while (big >= (64'd1 << 31)) begin
            big = big >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (big < (64'd1 << 30)) begin
            big = big << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + len / 2) / len;
            r[i] = c[i] < 0 ? -q : q;
        end
        ray.dx = r[0][31:0];
        ray.dy = r[1][31:0];
        ray.dz = r[2][31:0];
        ray.zero = 1'b0;
        return ray;
    endfunction

    // Pixel driver: a new transaction goes out only after the last one was taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || pixel_taken) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                pixel_t p;
                p = pending_pixels.pop_front();
                s_pixel_x <= p.x;
                s_pixel_y <= p.y;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: mirrors register writes, predicts accepted pixels, checks rays.
    always @(posedge aclk) begin
        pixel_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (prpd_pkg::cfg_index_t'(cfg_index))
                    prpd_pkg::CFG_IMAGE_WIDTH:
                        cam_width  <= cfg_data[prpd_pkg::SIZE_W-1:0];
                    prpd_pkg::CFG_IMAGE_HEIGHT:
                        cam_height <= cfg_data[prpd_pkg::SIZE_W-1:0];
                    prpd_pkg::CFG_HORIZONTAL_SCALE:
                        cam_hscale <= cfg_data[prpd_pkg::SCALE_W-1:0];
                    prpd_pkg::CFG_VERTICAL_SCALE:
                        cam_vscale <= cfg_data[prpd_pkg::SCALE_W-1:0];
                    prpd_pkg::CFG_VIEW_DIR_X: cam_dir_x <= cfg_data;
                    prpd_pkg::CFG_VIEW_DIR_Y: cam_dir_y <= cfg_data;
                    prpd_pkg::CFG_VIEW_DIR_Z: cam_dir_z <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pixel_taken = 1'b1;
                expected_rays.push_back(predict_ray(s_pixel_x, s_pixel_y));
            end
            if (m_valid && m_ready) begin
                if (expected_rays.size() == 0) begin
                    $error("ray transaction with nothing expected");
                    error_count++;
                end else begin
                    ray_t e;
                    e = expected_rays.pop_front();
                    rays_checked++;
                    if (e.zero) zero_rays_seen++;
                    if (m_ray_dir_x !== e.dx) begin
                        $error("ray_dir_x expected %0d actual %0d", e.dx, m_ray_dir_x);
                        error_count++;
                    end
                    if (m_ray_dir_y !== e.dy) begin
                        $error("ray_dir_y expected %0d actual %0d", e.dy, m_ray_dir_y);
                        error_count++;
                    end
                    if (m_ray_dir_z !== e.dz) begin
                        $error("ray_dir_z expected %0d actual %0d", e.dz, m_ray_dir_z);
                        error_count++;
                    end
                    if (m_zero_length !== e.zero) begin
                        $error("zero_length expected %0d actual %0d", e.zero, m_zero_length);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(prpd_pkg::cfg_index_t idx, logic [prpd_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_camera(int w, int h, logic [30:0] hs, logic [30:0] vs,
                              logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        write_reg(prpd_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(prpd_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(prpd_pkg::CFG_HORIZONTAL_SCALE, {1'b0, hs});
        write_reg(prpd_pkg::CFG_VERTICAL_SCALE, {1'b0, vs});
        write_reg(prpd_pkg::CFG_VIEW_DIR_X, dx);
        write_reg(prpd_pkg::CFG_VIEW_DIR_Y, dy);
        write_reg(prpd_pkg::CFG_VIEW_DIR_Z, dz);
    endtask

    task automatic queue_pixel(int x, int y);
        pixel_t p;
        p.x = COORD_W'(x);
        p.y = COORD_W'(y);
        pending_pixels.push_back(p);
    endtask

    // Mostly pixels inside the frame, some anywhere in the coordinate range.
    task automatic queue_random_pixels(int n);
        int w;
        int h;
        w = (cam_width == 0) ? 1 : int'(cam_width);
        h = (cam_height == 0) ? 1 : int'(cam_height);
        repeat (n) begin
            if ($urandom_range(3) == 0)
                queue_pixel($urandom_range(4095), $urandom_range(4095));
            else
                queue_pixel($urandom_range(w > 4096 ? 4095 : w - 1),
                            $urandom_range(h > 4096 ? 4095 : h - 1));
        end
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_pixels.size() != 0 || s_valid || expected_rays.size() != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_pressure(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pixel_x = '0;
        s_pixel_y = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        cycle_count = 0;
        rays_checked = 0;
        zero_rays_seen = 0;
        cam_width  = prpd_pkg::IMAGE_WIDTH_RST;
        cam_height = prpd_pkg::IMAGE_HEIGHT_RST;
        cam_hscale = prpd_pkg::HORIZONTAL_SCALE_RST;
        cam_vscale = prpd_pkg::VERTICAL_SCALE_RST;
        cam_dir_x  = prpd_pkg::VIEW_DIR_X_RST;
        cam_dir_y  = prpd_pkg::VIEW_DIR_Y_RST;
        cam_dir_z  = prpd_pkg::VIEW_DIR_Z_RST;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset camera: corners, center, and pixels beyond the frame.
        queue_pixel(0, 0);
        queue_pixel(639, 479);
        queue_pixel(320, 240);
        queue_pixel(319, 239);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        queue_pixel(12'hAAA, 12'h555);
        queue_pixel(12'h555, 12'hAAA);
        drain();

        // Zero-size image with the widest scales and extreme view directions, then a 4096 by 4096 one.
        set_camera(0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(1, 0);
        drain();
        set_camera(4096, 4096, 31'h7FFF_FFFF, 31'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        queue_pixel(0, 4095);
        queue_pixel(4095, 0);
        queue_pixel(2048, 2048);
        drain();

        // The pixel at the exact center of an odd frame with a null view
        // direction gives a zero-length sum; so does any pixel with zero scales.
        set_camera(641, 1, 31'd12915101, 31'd9686326, 32'h0, 32'h0, 32'h0);
        queue_pixel(320, 0);
        queue_pixel(321, 0);
        drain();
        set_camera(1, 1, 31'h0, 31'h0, 32'h0, 32'h0, 32'h0);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(7, 3);
        drain();

        // Random camera setups, each under one of the pressure patterns.
        for (int ph = 0; ph < 12; ph++) begin
            logic [31:0] dz;
            set_pressure(ph);
            dz = (ph % 3 == 0) ? $urandom() : 32'hFF00_0000 + $urandom_range(65535);
            if (ph % 5 == 4)
                set_camera($urandom_range(1, 4096), $urandom_range(1, 4096),
                           31'({$urandom(), 1'b1}), 31'({$urandom(), 1'b0}), $urandom(),
                           $urandom(), $urandom());
            else
                set_camera($urandom_range(1, 64), $urandom_range(1, 64),
                           31'($urandom_range(32'h0200_0000)),
                           31'($urandom_range(32'h0200_0000)),
                           $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                           dz);
            queue_random_pixels(52);
            drain();
        end
        set_pressure(0);
        set_camera(prpd_pkg::IMAGE_WIDTH_RST, prpd_pkg::IMAGE_HEIGHT_RST,
                   prpd_pkg::HORIZONTAL_SCALE_RST, prpd_pkg::VERTICAL_SCALE_RST,
                   prpd_pkg::VIEW_DIR_X_RST, prpd_pkg::VIEW_DIR_Y_RST,
                   prpd_pkg::VIEW_DIR_Z_RST);
        queue_random_pixels(20);
        drain();
        repeat (150) @(posedge aclk);

        $display("Checked %0d ray directions (%0d zero-length) over 18 camera setups",
                 rays_checked, zero_rays_seen);
        $display("with idle, stalled and back-to-back handshakes; %0d errors.",
                 error_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/prpd_pkg.sv
sv/prpd_div.sv
sv/pinhole_primary_ray_direction.sv
sv/prpd_chk.sv
dv/tb_pinhole_primary_ray_direction.sv
